### design/psqd_pkg.sv
// ----------------------------------------------------------------------------
// Per-source command queue dispatcher package
// Shared types, event codes and flag positions.
// ----------------------------------------------------------------------------
`default_nettype none
package psqd_pkg;

  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_FULL     = 3'd1,
    EV_BAD      = 3'd2,
    EV_DISPATCH = 3'd3,
    EV_DONE_OK  = 3'd4,
    EV_FAILED   = 3'd5,
    EV_TIMEOUT  = 3'd6,
    EV_PASS_END = 3'd7
  } event_code_t;

  typedef enum logic [0:0] {
    CFG_PALLET_COUNT  = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_READ,
    ST_ENQ_DONE,
    ST_TICK_READ,
    ST_TICK_EVAL,
    ST_CHAN_SWEEP,
    ST_PASS_END,
    ST_OUT_WAIT
  } state_t;

  // Flag bits of a ring entry.
  localparam int unsigned FLAG_PENDING = 0;
  localparam int unsigned FLAG_BUSY    = 1;
  localparam int unsigned FLAG_DONE    = 2;
  localparam int unsigned FLAG_ERROR   = 3;

  localparam logic [9:0] WAIT_MAX = 10'd1023;

  // Controller to datapath commands.
  typedef struct packed {
    logic start_enq;    // latch input item, start flag read for enqueue
    logic enq_commit;   // decide enqueue, write entry, present result
    logic start_tick;   // latch input item, set first pallet of the pass
    logic tick_read;    // read flags of current pallet head
    logic tick_eval;    // evaluate current pallet head, maybe emit
    logic sweep;        // reopen freed channels
    logic pass_end;     // present pass end result
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic emitted;      // current eval produces a result
    logic last_pallet;  // evaluated pallet was the last of the pass
    logic out_busy;     // output register holds an untaken result
  } stat_t;

endpackage
`default_nettype wire

### design/psqd_ctrl.sv
// ----------------------------------------------------------------------------
// Dispatcher controller
// Sequences enqueue and dispatch passes over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module psqd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_req_type,
  output logic                  in_stall,
  input  wire psqd_pkg::stat_t  stat,
  output psqd_pkg::ctrl_t       ctrl
);

  psqd_pkg::state_t state_r, state_nxt;
  psqd_pkg::state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psqd_pkg::ST_IDLE;
      ret_r   <= psqd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      psqd_pkg::ST_IDLE: begin
        if (in_valid && !stat.out_busy) begin
          state_nxt = in_req_type ? psqd_pkg::ST_TICK_READ : psqd_pkg::ST_ENQ_READ;
        end
      end
      psqd_pkg::ST_ENQ_READ:  state_nxt = psqd_pkg::ST_ENQ_DONE;
      psqd_pkg::ST_ENQ_DONE:  state_nxt = psqd_pkg::ST_IDLE;
      psqd_pkg::ST_TICK_READ: state_nxt = psqd_pkg::ST_TICK_EVAL;
      psqd_pkg::ST_TICK_EVAL: begin
        if (stat.emitted) begin
          state_nxt = psqd_pkg::ST_OUT_WAIT;
          ret_nxt   = stat.last_pallet ? psqd_pkg::ST_CHAN_SWEEP : psqd_pkg::ST_TICK_READ;
        end else begin
          state_nxt = stat.last_pallet ? psqd_pkg::ST_CHAN_SWEEP : psqd_pkg::ST_TICK_READ;
        end
      end
      psqd_pkg::ST_OUT_WAIT: begin
        if (!stat.out_busy) begin
          state_nxt = ret_r;
        end
      end
      psqd_pkg::ST_CHAN_SWEEP: state_nxt = psqd_pkg::ST_PASS_END;
      psqd_pkg::ST_PASS_END:   state_nxt = psqd_pkg::ST_IDLE;
      default:                 state_nxt = psqd_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    case (state_r)
      psqd_pkg::ST_IDLE: begin
        in_stall = stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          ctrl.start_enq  = !in_req_type;
          ctrl.start_tick = in_req_type;
        end
      end
      psqd_pkg::ST_ENQ_READ:   ctrl.enq_commit = 1'b0;
      psqd_pkg::ST_ENQ_DONE:   ctrl.enq_commit = 1'b1;
      psqd_pkg::ST_TICK_READ:  ctrl.tick_read  = 1'b1;
      psqd_pkg::ST_TICK_EVAL:  ctrl.tick_eval  = 1'b1;
      psqd_pkg::ST_CHAN_SWEEP: ctrl.sweep      = 1'b1;
      psqd_pkg::ST_PASS_END:   ctrl.pass_end   = 1'b1;
      psqd_pkg::ST_OUT_WAIT:   ctrl            = '0;
      default:                 ctrl            = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/psqd_datapath.sv
// ----------------------------------------------------------------------------
// Dispatcher datapath
// Ring stores, pointers, channel state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module psqd_datapath #(
  parameter int unsigned PALLETS      = 32,
  parameter int unsigned RING_DEPTH   = 8,
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned COMMAND_BITS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire psqd_pkg::ctrl_t  ctrl,
  output psqd_pkg::stat_t       stat,
  input  wire logic [5:0]       in_pallet_index,
  input  wire logic [63:0]      in_command_word,
  input  wire logic [15:0]      in_complete_bits,
  input  wire logic [15:0]      in_success_bits,
  input  wire logic [5:0]       pallet_count,
  input  wire logic [9:0]       timeout_ticks,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_event_code,
  output logic [5:0]            out_event_pallet,
  output logic [2:0]            out_slot,
  output logic [3:0]            out_channel_number,
  output logic [63:0]           out_channel_command,
  output logic                  out_now_full,
  output logic                  out_last_event
);

  localparam int unsigned PW = (PALLETS > 1) ? $clog2(PALLETS) : 1;
  localparam int unsigned RW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EW = PW + RW;
  localparam int unsigned ENTRIES = PALLETS * RING_DEPTH;

  // Entry store: command memory and flag memory (cleared by valid bits).
  logic [COMMAND_BITS-1:0] cmd_mem [ENTRIES];
  logic [3:0]              flag_mem [ENTRIES];
  logic [ENTRIES-1:0]      flag_vld_r;

  logic [RW-1:0] wp_r [PALLETS];
  logic [RW-1:0] rp_r [PALLETS];
  logic [CW-1:0] pch_r [PALLETS];
  logic [CHANNELS-1:0] in_use_r, trig_r;
  logic [9:0]    wait_r [CHANNELS];
  logic [CW-1:0] next_ch_r;
  logic [PW-1:0] scan_start_r;

  // Latched item.
  logic [5:0]  idx_r;
  logic [63:0] cmdw_r;
  logic [15:0] comp_r, succ_r;

  // Pass state.
  logic [PW-1:0] cur_r;
  logic [5:0]    done_cnt_r;
  logic          paused_r;
  logic [5:0]    count_r;
  logic [9:0]    limit_r;

  // Registered memory reads.
  logic [3:0]              flag_rd_r;
  logic                    flag_rdv_r;
  logic [3:0]              nflag_rd_r;
  logic                    nflag_rdv_r;
  logic [COMMAND_BITS-1:0] cmd_rd_r;

  function automatic logic [COMMAND_BITS-1:0] in_cmd_trunc(input logic [63:0] v);
    in_cmd_trunc = v[COMMAND_BITS-1:0];
  endfunction

  logic [5:0] count_c;
  always_comb begin
    if (pallet_count == 6'd0) count_c = 6'd1;
    else if (32'(pallet_count) > PALLETS) count_c = 6'(PALLETS);
    else count_c = pallet_count;
  end

  logic [PW-1:0] p_enq;
  logic [RW-1:0] w_enq, nw_enq;
  logic          bad_enq;
  assign bad_enq = (idx_r == 6'd0) || (idx_r > count_r);
  assign p_enq   = PW'(idx_r - 6'd1);
  assign w_enq   = wp_r[p_enq];
  assign nw_enq  = RW'(w_enq + 1'b1);

  logic [3:0] flag_cur, nflag_cur;
  assign flag_cur  = flag_rdv_r  ? flag_rd_r  : 4'd0;
  assign nflag_cur = nflag_rdv_r ? nflag_rd_r : 4'd0;

  // Head evaluation.
  logic [RW-1:0] r_cur;
  logic [CW-1:0] ch_busy, ch_new;
  logic          comp_b, succ_b;
  logic [9:0]    wait_inc;
  logic [PW-1:0] cur_next;
  assign r_cur    = rp_r[cur_r];
  assign ch_busy  = pch_r[cur_r];
  assign ch_new   = next_ch_r;
  assign comp_b   = (32'(ch_busy) < 16) ? comp_r[4'(ch_busy)] : 1'b0;
  assign succ_b   = (32'(ch_busy) < 16) ? succ_r[4'(ch_busy)] : 1'b0;
  assign wait_inc = (wait_r[ch_busy] < psqd_pkg::WAIT_MAX) ? wait_r[ch_busy] + 10'd1
                                                           : wait_r[ch_busy];
  assign cur_next = (32'(cur_r) + 1 >= 32'(count_r)) ? '0 : PW'(cur_r + 1'b1);

  logic ev_busy_done, ev_timeout, ev_dispatch, ev_pause, ev_any;
  always_comb begin
    ev_busy_done = flag_cur[psqd_pkg::FLAG_BUSY] && comp_b;
    ev_timeout   = flag_cur[psqd_pkg::FLAG_BUSY] && !comp_b && (wait_inc >= limit_r);
    ev_dispatch  = !flag_cur[psqd_pkg::FLAG_BUSY] && !paused_r &&
                   flag_cur[psqd_pkg::FLAG_PENDING] && !in_use_r[ch_new];
    ev_pause     = !flag_cur[psqd_pkg::FLAG_BUSY] && !paused_r &&
                   flag_cur[psqd_pkg::FLAG_PENDING] && in_use_r[ch_new];
    ev_any       = ev_busy_done || ev_timeout || ev_dispatch;
  end

  assign stat.emitted     = ctrl.tick_eval && ev_any;
  assign stat.last_pallet = (done_cnt_r + 6'd1 >= count_r);
  assign stat.out_busy    = out_valid;

  // Memory port addresses.
  logic [EW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [3:0]    wr_flag;
  logic          cmd_we;
  always_comb begin
    rd_addr  = {cur_r, r_cur};
    if (ctrl.start_enq || !ctrl.tick_read) begin
      rd_addr = {PW'(in_pallet_index - 6'd1), wp_r[PW'(in_pallet_index - 6'd1)]};
    end
    if (ctrl.tick_read) rd_addr = {cur_r, r_cur};
    wr_addr = {cur_r, r_cur};
    wr_en   = 1'b0;
    wr_flag = flag_cur;
    cmd_we  = 1'b0;
    if (ctrl.enq_commit && !bad_enq &&
        !(flag_cur[psqd_pkg::FLAG_PENDING] || flag_cur[psqd_pkg::FLAG_BUSY])) begin
      wr_addr = {p_enq, w_enq};
      wr_en   = 1'b1;
      cmd_we  = 1'b1;
      wr_flag = 4'b0001;
    end else if (ctrl.tick_eval) begin
      if (ev_busy_done) begin
        wr_en   = 1'b1;
        wr_flag = (flag_cur & 4'b1101) | 4'b0100 | (succ_b ? 4'b0000 : 4'b1000);
      end else if (ev_timeout) begin
        wr_en   = 1'b1;
        wr_flag = (flag_cur & 4'b1101) | 4'b1100;
      end else if (ev_dispatch) begin
        wr_en   = 1'b1;
        wr_flag = (flag_cur & 4'b1110) | 4'b0010;
      end
    end
  end

  // The enqueue path reads the written slot and the one after it.
  logic [EW-1:0] enq_rd_addr, enq_nrd_addr;
  logic [PW-1:0] p_in;
  assign p_in         = PW'(in_pallet_index - 6'd1);
  assign enq_rd_addr  = {p_in, wp_r[p_in]};
  assign enq_nrd_addr = {p_in, RW'(wp_r[p_in] + 1'b1)};

  always_ff @(posedge clk) begin
    if (cmd_we) cmd_mem[wr_addr] <= in_cmd_trunc(cmdw_r);
    cmd_rd_r <= cmd_mem[rd_addr];
    if (wr_en) flag_mem[wr_addr] <= wr_flag;
    if (ctrl.start_enq) begin
      flag_rd_r   <= flag_mem[enq_rd_addr];
      flag_rdv_r  <= flag_vld_r[enq_rd_addr];
      nflag_rd_r  <= flag_mem[enq_nrd_addr];
      nflag_rdv_r <= flag_vld_r[enq_nrd_addr];
    end else if (ctrl.tick_read) begin
      flag_rd_r   <= flag_mem[rd_addr];
      flag_rdv_r  <= flag_vld_r[rd_addr];
    end
  end

  // Control and pointer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_vld_r   <= '0;
      in_use_r     <= '0;
      trig_r       <= '0;
      next_ch_r    <= '0;
      scan_start_r <= '0;
      paused_r     <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < PALLETS; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
      for (int c = 0; c < CHANNELS; c++) wait_r[c] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (wr_en) flag_vld_r[wr_addr] <= 1'b1;

      if (ctrl.enq_commit) begin
        out_valid          <= 1'b1;
        out_event_pallet   <= idx_r;
        out_channel_number <= '0;
        out_channel_command <= '0;
        out_last_event     <= 1'b1;
        out_now_full       <= 1'b0;
        if (bad_enq) begin
          out_event_code <= psqd_pkg::EV_BAD;
          out_slot       <= '0;
        end else if (flag_cur[psqd_pkg::FLAG_PENDING] || flag_cur[psqd_pkg::FLAG_BUSY]) begin
          out_event_code <= psqd_pkg::EV_FULL;
          out_slot       <= 3'(w_enq);
        end else begin
          out_event_code <= psqd_pkg::EV_ACCEPTED;
          out_slot       <= 3'(w_enq);
          wp_r[p_enq]    <= nw_enq;
          // The following slot is the written one when the ring wraps onto itself.
          out_now_full   <= (RING_DEPTH == 1) ? 1'b1 :
                            (nflag_cur[psqd_pkg::FLAG_PENDING] ||
                             nflag_cur[psqd_pkg::FLAG_BUSY]);
        end
      end

      if (ctrl.start_tick) begin
        cur_r      <= (32'(scan_start_r) < 32'(count_c)) ? scan_start_r : '0;
        done_cnt_r <= '0;
        paused_r   <= 1'b0;
      end

      if (ctrl.tick_eval) begin
        // A finished head restarts its channel's wait count.
        if (flag_cur[psqd_pkg::FLAG_BUSY]) begin
          wait_r[ch_busy] <= (ev_busy_done || ev_timeout) ? '0 : wait_inc;
        end
        out_event_pallet    <= 6'(cur_r) + 6'd1;
        out_slot            <= 3'(r_cur);
        out_now_full        <= 1'b0;
        out_last_event      <= 1'b0;
        out_channel_command <= '0;
        if (ev_busy_done || ev_timeout) begin
          out_valid          <= 1'b1;
          out_event_code     <= ev_timeout ? psqd_pkg::EV_TIMEOUT :
                                succ_b ? psqd_pkg::EV_DONE_OK : psqd_pkg::EV_FAILED;
          out_channel_number <= 4'(ch_busy);
          trig_r[ch_busy]    <= 1'b0;
          rp_r[cur_r]        <= RW'(r_cur + 1'b1);
        end else if (ev_dispatch) begin
          out_valid           <= 1'b1;
          out_event_code      <= psqd_pkg::EV_DISPATCH;
          out_channel_number  <= 4'(ch_new);
          out_channel_command <= 64'(cmd_rd_r);
          trig_r[ch_new]      <= 1'b1;
          in_use_r[ch_new]    <= 1'b1;
          pch_r[cur_r]        <= ch_new;
          next_ch_r           <= (32'(ch_new) + 1 >= CHANNELS) ? '0 : CW'(ch_new + 1'b1);
        end else if (ev_pause) begin
          paused_r     <= 1'b1;
          scan_start_r <= cur_r;
        end
        cur_r      <= cur_next;
        done_cnt_r <= done_cnt_r + 6'd1;
      end

      if (ctrl.sweep) begin
        if (!paused_r) scan_start_r <= '0;
        in_use_r <= in_use_r & trig_r;
      end

      if (ctrl.pass_end) begin
        out_valid           <= 1'b1;
        out_event_code      <= psqd_pkg::EV_PASS_END;
        out_event_pallet    <= '0;
        out_slot            <= '0;
        out_channel_number  <= '0;
        out_channel_command <= '0;
        out_now_full        <= 1'b0;
        out_last_event      <= 1'b1;
      end
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (ctrl.start_enq || ctrl.start_tick) begin
      idx_r   <= in_pallet_index;
      cmdw_r  <= in_command_word;
      comp_r  <= in_complete_bits;
      succ_r  <= in_success_bits;
      count_r <= count_c;
      limit_r <= (timeout_ticks == 10'd0) ? 10'd1 : timeout_ticks;
    end
  end

endmodule
`default_nettype wire

### design/per_source_command_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// Per-source command queue dispatcher
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// An enqueue passes through ENQ_READ and ENQ_DONE, then presents its single
// result, and the input stays stalled until that result is taken. A tick walks
// the pallets in use one at a time through the flag memory, with a read state
// and an evaluate state per pallet, then the channel reopen sweep and the pass
// end result. Every other result of the pass holds the walk in the output wait
// state until it is taken, longer while the output is stalled.
`default_nettype none
module per_source_command_queue_dispatcher #(
  parameter int unsigned PALLETS      = 32,
  parameter int unsigned RING_DEPTH   = 8,
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned COMMAND_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [5:0]  in_pallet_index,
  input  wire logic [63:0] in_command_word,
  input  wire logic [15:0] in_complete_bits,
  input  wire logic [15:0] in_success_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_code,
  output logic [5:0]       out_event_pallet,
  output logic [2:0]       out_slot,
  output logic [3:0]       out_channel_number,
  output logic [63:0]      out_channel_command,
  output logic             out_now_full,
  output logic             out_last_event,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  logic [5:0] pallet_count_r;
  logic [9:0] timeout_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pallet_count_r  <= 6'd32;
      timeout_ticks_r <= 10'd625;
    end else if (cfg_valid) begin
      case (cfg_index)
        psqd_pkg::CFG_PALLET_COUNT:  pallet_count_r  <= cfg_data[5:0];
        psqd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  psqd_pkg::ctrl_t ctrl;
  psqd_pkg::stat_t stat;

  psqd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .stat        (stat),
    .ctrl        (ctrl)
  );

  psqd_datapath #(
    .PALLETS      (PALLETS),
    .RING_DEPTH   (RING_DEPTH),
    .CHANNELS     (CHANNELS),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .stat                (stat),
    .in_pallet_index     (in_pallet_index),
    .in_command_word     (in_command_word),
    .in_complete_bits    (in_complete_bits),
    .in_success_bits     (in_success_bits),
    .pallet_count        (pallet_count_r),
    .timeout_ticks       (timeout_ticks_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_code      (out_event_code),
    .out_event_pallet    (out_event_pallet),
    .out_slot            (out_slot),
    .out_channel_number  (out_channel_number),
    .out_channel_command (out_channel_command),
    .out_now_full        (out_now_full),
    .out_last_event      (out_last_event)
  );

endmodule
`default_nettype wire

### design/psqd_checker.sv
// ----------------------------------------------------------------------------
// Dispatcher port checker
// Port-level properties of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module psqd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_event_code,
  input wire logic [5:0] out_event_pallet,
  input wire logic       out_last_event
);

  // A result is held while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code))
    else $error("result changed while stalled");

  // Pass end always closes a transaction and concerns no pallet.
  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == psqd_pkg::EV_PASS_END |->
      out_last_event && out_event_pallet == 6'd0)
    else $error("malformed pass end");

  // No new item is taken while a result waits.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("item taken while result pending");

  // An item is only accepted when the result register is empty.
  a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid)
    else $error("item accepted beside a held result");

endmodule

bind per_source_command_queue_dispatcher psqd_checker u_psqd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code),
  .out_event_pallet (out_event_pallet),
  .out_last_event (out_last_event)
);
`default_nettype wire

### tb/sv/tb_per_source_command_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// Per-source command queue dispatcher testbench
// Drives enqueue and tick transactions with random gaps and output stalls,
// predicts every event from an internal model of the rings and channels, and
// compares each result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_per_source_command_queue_dispatcher;

  localparam int NP = 32;
  localparam int RD = 8;
  localparam int NC = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  pallet;
    logic [63:0] cmd;
    logic [15:0] complete;
    logic [15:0] success;
  } request_t;

  typedef struct packed {
    psqd_pkg::event_code_t code;
    logic [5:0]  pallet;
    logic [2:0]  slot;
    logic [3:0]  chan;
    logic [63:0] cmd;
    logic        full;
    logic        last;
  } event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire  in_stall;
  logic in_req_type = 1'b0;
  logic [5:0] in_pallet_index = '0;
  logic [63:0] in_command_word = '0;
  logic [15:0] in_complete_bits = '0;
  logic [15:0] in_success_bits = '0;
  wire  out_valid;
  logic out_stall = 1'b0;
  wire [2:0] out_event_code;
  wire [5:0] out_event_pallet;
  wire [2:0] out_slot;
  wire [3:0] out_channel_number;
  wire [63:0] out_channel_command;
  wire out_now_full;
  wire out_last_event;
  logic cfg_valid = 1'b0;
  wire  cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  per_source_command_queue_dispatcher dut (.*);

  initial forever #5 clk = ~clk;

  // Predictor state.
  logic [63:0] m_cmd [NP*RD];
  logic [3:0]  m_flags [NP*RD];
  logic [2:0]  m_wp [NP];
  logic [2:0]  m_rp [NP];
  logic [3:0]  m_pch [NP];
  logic        m_inuse [NC];
  logic        m_trig [NC];
  logic [9:0]  m_wait [NC];
  logic [3:0]  m_next;
  logic [4:0]  m_start;
  logic [5:0]  r_pallets;
  logic [9:0]  r_timeout;

  request_t pending_reqs[$];
  event_t   expected_events[$];
  int errors = 0;
  int n_results = 0;
  int n_ticks = 0;
  int n_enq = 0;
  int cycles = 0;
  bit hold_sender = 0;
  bit drain_req = 0;
  bit hold_off_req = 0;
  bit hold_off_done = 0;
  int hold_cnt = 0;

  function automatic int pallets_in_use();
    if (r_pallets == 0) return 1;
    if (r_pallets > NP) return NP;
    return r_pallets;
  endfunction

  function automatic void push_event(psqd_pkg::event_code_t c, int p, int s, int ch,
                                     logic [63:0] cm, bit f);
    event_t ev;
    ev.code = c; ev.pallet = p[5:0]; ev.slot = s[2:0]; ev.chan = ch[3:0];
    ev.cmd = cm; ev.full = f; ev.last = 1'b0;
    expected_events.push_back(ev);
  endfunction

  function automatic void predict_events(request_t rq);
    int idx, p, w, e, nw, cnt, lim, i, r, ch;
    bit paused, ok;
    logic [3:0] f;
    if (!rq.req_type) begin
      idx = rq.pallet;
      if (idx == 0 || idx > pallets_in_use()) begin
        push_event(psqd_pkg::EV_BAD, idx, 0, 0, '0, 0);
      end else begin
        p = idx - 1; w = m_wp[p]; e = p*RD + w;
        if (m_flags[e][psqd_pkg::FLAG_PENDING] || m_flags[e][psqd_pkg::FLAG_BUSY]) begin
          push_event(psqd_pkg::EV_FULL, idx, w, 0, '0, 0);
        end else begin
          m_cmd[e] = rq.cmd;
          m_flags[e][psqd_pkg::FLAG_DONE] = 0; m_flags[e][psqd_pkg::FLAG_ERROR] = 0;
          m_flags[e][psqd_pkg::FLAG_PENDING] = 1;
          nw = (w + 1) % RD;
          m_wp[p] = nw;
          push_event(psqd_pkg::EV_ACCEPTED, idx, w, 0, '0,
                     m_flags[p*RD+nw][psqd_pkg::FLAG_PENDING] |
                     m_flags[p*RD+nw][psqd_pkg::FLAG_BUSY]);
        end
      end
    end else begin
      cnt = pallets_in_use();
      lim = (r_timeout == 0) ? 1 : r_timeout;
      i = (m_start < cnt) ? m_start : 0;
      paused = 0;
      for (int j = 0; j < cnt; j++) begin
        r = m_rp[i]; e = i*RD + r; f = m_flags[e];
        if (f[psqd_pkg::FLAG_BUSY]) begin
          ch = m_pch[i];
          if (m_wait[ch] < psqd_pkg::WAIT_MAX) m_wait[ch]++;
          if (rq.complete[ch]) begin
            ok = rq.success[ch];
            m_trig[ch] = 0; m_wait[ch] = 0;
            f[psqd_pkg::FLAG_BUSY] = 0; f[psqd_pkg::FLAG_DONE] = 1;
            if (!ok) f[psqd_pkg::FLAG_ERROR] = 1;
            m_flags[e] = f;
            m_rp[i] = (r + 1) % RD;
            push_event(ok ? psqd_pkg::EV_DONE_OK : psqd_pkg::EV_FAILED, i+1, r, ch, '0, 0);
          end else if (m_wait[ch] >= lim) begin
            m_trig[ch] = 0; m_wait[ch] = 0;
            f[psqd_pkg::FLAG_BUSY] = 0; f[psqd_pkg::FLAG_DONE] = 1;
            f[psqd_pkg::FLAG_ERROR] = 1;
            m_flags[e] = f;
            m_rp[i] = (r + 1) % RD;
            push_event(psqd_pkg::EV_TIMEOUT, i+1, r, ch, '0, 0);
          end
        end else if (!paused && f[psqd_pkg::FLAG_PENDING]) begin
          ch = m_next;
          if (m_inuse[ch]) begin
            paused = 1; m_start = i;
          end else begin
            m_trig[ch] = 1; m_inuse[ch] = 1; m_pch[i] = ch;
            f[psqd_pkg::FLAG_PENDING] = 0; f[psqd_pkg::FLAG_BUSY] = 1; m_flags[e] = f;
            m_next = ch + 1;
            push_event(psqd_pkg::EV_DISPATCH, i+1, r, ch, m_cmd[e], 0);
          end
        end
        i = (i + 1) % cnt;
      end
      if (!paused) m_start = 0;
      for (int c = 0; c < NC; c++)
        if (m_inuse[c] && !m_trig[c]) m_inuse[c] = 0;
      push_event(psqd_pkg::EV_PASS_END, 0, 0, 0, '0, 0);
    end
    expected_events[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
  endtask

  // Sender: bursts and gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_events({in_req_type, in_pallet_index, in_command_word, in_complete_bits,
                        in_success_bits});
        if (in_req_type) n_ticks++; else n_enq++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (hold_sender || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          request_t rq;
          rq = pending_reqs.pop_front();
          in_valid <= 1'b1;
          {in_req_type, in_pallet_index, in_command_word, in_complete_bits,
           in_success_bits} <= rq;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      if (hold_cnt >= LONG_HOLD - 1) hold_off_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Receiver: stall pattern plus long hold-offs.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        event_t ev;
        n_results++;
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result", out_event_code, 0);
        end else begin
          ev = expected_events.pop_front();
          if (out_event_code !== ev.code) report_mismatch("event_code", out_event_code, ev.code);
          if (out_event_pallet !== ev.pallet)
            report_mismatch("event_pallet", out_event_pallet, ev.pallet);
          if (out_slot !== ev.slot) report_mismatch("slot", out_slot, ev.slot);
          if (out_channel_number !== ev.chan)
            report_mismatch("channel_number", out_channel_number, ev.chan);
          if (out_channel_command !== ev.cmd)
            report_mismatch("channel_command", out_channel_command, ev.cmd);
          if (out_now_full !== ev.full) report_mismatch("now_full", out_now_full, ev.full);
          if (out_last_event !== ev.last)
            report_mismatch("last_event", out_last_event, ev.last);
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
      end else if (drain_req) begin
        out_stall <= 1'b0;
      end else if ((stall_phase / 200) % 3 == 2) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_per_source_command_queue_dispatcher failed");
      $finish;
    end
  end

  function automatic request_t make_enq(int pal, logic [63:0] cmd);
    request_t rq;
    rq = '0; rq.req_type = 0; rq.pallet = pal[5:0]; rq.cmd = cmd;
    rq.complete = 16'($urandom); rq.success = 16'($urandom);
    return rq;
  endfunction

  function automatic request_t make_tick(logic [15:0] comp, logic [15:0] succ);
    request_t rq;
    rq = '0; rq.req_type = 1; rq.complete = comp; rq.success = succ;
    rq.pallet = 6'($urandom); rq.cmd = {$urandom, $urandom};
    return rq;
  endfunction

  task automatic wait_idle(int settle);
    while (pending_reqs.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(psqd_pkg::cfg_index_t idx, logic [9:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == psqd_pkg::CFG_PALLET_COUNT) r_pallets = val[5:0]; else r_timeout = val;
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int maxpal);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 5)
        pending_reqs.push_back(make_enq($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                        : $urandom_range(1, maxpal), {$urandom, $urandom}));
      else
        pending_reqs.push_back(make_tick(16'($urandom) & 16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    for (int i = 0; i < NP*RD; i++) begin m_cmd[i] = '0; m_flags[i] = '0; end
    for (int i = 0; i < NP; i++) begin m_wp[i] = 0; m_rp[i] = 0; m_pch[i] = 0; end
    for (int i = 0; i < NC; i++) begin m_inuse[i] = 0; m_trig[i] = 0; m_wait[i] = 0; end
    m_next = 0; m_start = 0; r_pallets = 32; r_timeout = 625;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad pallets, extremes of the command, a full ring, ticks.
    pending_reqs.push_back(make_enq(0, '0));
    pending_reqs.push_back(make_enq(33, '1));
    pending_reqs.push_back(make_enq(63, '1));
    pending_reqs.push_back(make_enq(32, '1));
    for (int k = 0; k < 9; k++) pending_reqs.push_back(make_enq(1, 64'h1 << (k * 7)));
    pending_reqs.push_back(make_tick('0, '0));
    pending_reqs.push_back(make_tick(16'hffff, 16'h0001));
    pending_reqs.push_back(make_tick(16'hffff, 16'hffff));
    pending_reqs.push_back(make_tick('0, '0));
    pending_reqs.push_back(make_tick(16'hffff, '0));
    wait_idle(80);

    // Minimum pallets and the shortest timeout drive timeouts and channel busy.
    write_reg(psqd_pkg::CFG_PALLET_COUNT, 10'd0);
    write_reg(psqd_pkg::CFG_TIMEOUT_TICKS, 10'd0);
    for (int k = 0; k < 6; k++) pending_reqs.push_back(make_enq(1, {$urandom, $urandom}));
    pending_reqs.push_back(make_enq(2, '0));
    for (int k = 0; k < 8; k++) pending_reqs.push_back(make_tick('0, '0));
    wait_idle(80);

    write_reg(psqd_pkg::CFG_PALLET_COUNT, 10'd4);
    write_reg(psqd_pkg::CFG_TIMEOUT_TICKS, 10'd3);
    random_phase(70, 4);
    // Long receiver hold-off while the sender keeps offering.
    hold_off_req = 1;
    wait_idle(80);

    write_reg(psqd_pkg::CFG_PALLET_COUNT, 10'd63);
    write_reg(psqd_pkg::CFG_TIMEOUT_TICKS, 10'd1023);
    random_phase(50, 32);
    wait_idle(120);

    write_reg(psqd_pkg::CFG_PALLET_COUNT, 10'd20);
    write_reg(psqd_pkg::CFG_TIMEOUT_TICKS, 10'd2);
    random_phase(40, 21);
    // Sender pauses until everything has drained, then continues.
    hold_sender = 1;
    drain_req = 1;
    while (expected_events.size() != 0 || in_valid) @(posedge clk);
    hold_sender = 0;
    drain_req = 0;
    random_phase(40, 20);
    wait_idle(120);

    $display("Covered %0d enqueues and %0d dispatch passes, %0d results checked.",
             n_enq, n_ticks, n_results);
    if (errors == 0) begin
      $display("tb_per_source_command_queue_dispatcher passed");
    end else begin
      $display("tb_per_source_command_queue_dispatcher failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
